FILE: rtl/core/dcc_loco_throttle_packet_builder_top_assert.svh
// Assertion macros for the DCC loco throttle packet builder checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef DCC_LOCO_THROTTLE_PACKET_BUILDER_TOP_ASSERT_SVH
`define DCC_LOCO_THROTTLE_PACKET_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define DCL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define DCL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define DCL_ASSERT_ANY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dcl_pkg.sv
// Shared types and constants for the DCC loco throttle packet builder.
// No dependencies; imported by every module of the block.
package dcl_pkg;

  localparam int unsigned ADDR_W      = 14;
  localparam int unsigned SPEED_W     = 7;
  localparam int unsigned STEPS_W     = 8;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [ADDR_W-1:0]  SHORT_ADDR_MAX = ADDR_W'(127);
  localparam logic [ADDR_W-1:0]  LOCO_ADDR_MAX  = ADDR_W'(10239);
  localparam logic [SPEED_W-1:0] THROTTLE_MAX   = SPEED_W'(126);

  localparam logic [STEPS_W-1:0] STEPS_28  = 8'd28;
  localparam logic [STEPS_W-1:0] STEPS_128 = 8'd128;

  localparam logic [7:0] SPEED128_MARK = 8'h3F;
  localparam logic [1:0] LONG_ADDR_TAG = 2'b11;
  localparam logic [7:0] SPEED28_BASE  = 8'h40;
  localparam logic [7:0] ESTOP28_BYTE  = 8'h41;
  localparam logic [7:0] FWD28_BIT     = 8'h20;
  localparam logic [1:0] REPEAT_VALID  = 2'd3;
  localparam logic       MODE128_RST   = 1'b1;

  // 28-step rescale: (speed * 10 + 36) / 46, divide done by reciprocal
  localparam int unsigned S28_MUL   = 10;
  localparam int unsigned S28_ADD   = 36;
  localparam int unsigned S28_SHIFT = 16;
  localparam int unsigned S28_RECIP = ((1 << S28_SHIFT) + 45) / 46;
  localparam int unsigned S28_OFS   = 3;
  localparam int unsigned S28_NUM_W = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_THROTTLE     = 2'd0,
    REQ_MODE_SET     = 2'd1,
    REQ_MODE_DEFAULT = 2'd2
  } req_t;

  typedef enum logic {
    CFG_LOCO_ADDRESS     = 1'b0,
    CFG_INITIAL_MODE_128 = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic               dir_forward;
    logic [SPEED_W-1:0] speed_value;
    logic               estop_request;
    logic [STEPS_W-1:0] steps_value;
  } item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               estop;
    logic               forward;
    logic               mode_128;
    logic               overridden;
  } loco_state_t;

  typedef struct packed {
    logic [2:0] packet_length;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [1:0] repeat_count;
  } pkt_t;

endpackage

FILE: rtl/core/dcl_state.sv
// Locomotive state registers and request update logic.
// Depends on dcl_pkg.
module dcl_state import dcl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  item_t       item,
  output logic        changed,
  output loco_state_t state_nxt
);

  loco_state_t state_r;
  logic        steps_ok;
  logic        want_128;

  assign steps_ok = (item.steps_value == STEPS_28) || (item.steps_value == STEPS_128);
  assign want_128 = (item.steps_value == STEPS_128);

  always_comb begin
    state_nxt = state_r;
    changed   = 1'b0;
    case (item.req_type)
      REQ_THROTTLE: begin
        if (item.estop_request) begin
          if ((state_r.forward != item.dir_forward) || !state_r.estop) begin
            changed           = 1'b1;
            state_nxt.forward = item.dir_forward;
            state_nxt.estop   = 1'b1;
            state_nxt.speed   = '0;
          end
        end else if (item.speed_value <= THROTTLE_MAX) begin
          if ((state_r.forward != item.dir_forward) || state_r.estop ||
              (state_r.speed != item.speed_value)) begin
            changed           = 1'b1;
            state_nxt.forward = item.dir_forward;
            state_nxt.estop   = 1'b0;
            state_nxt.speed   = item.speed_value;
          end
        end
      end
      REQ_MODE_SET: begin
        if (steps_ok) begin
          // mark the override even when the mode already matches
          state_nxt.overridden = 1'b1;
          if (state_r.mode_128 != want_128) begin
            state_nxt.mode_128 = want_128;
            changed            = 1'b1;
          end
        end
      end
      REQ_MODE_DEFAULT: begin
        if (!state_r.overridden && steps_ok && (state_r.mode_128 != want_128)) begin
          state_nxt.mode_128 = want_128;
          changed            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.speed      <= '0;
      state_r.estop      <= 1'b0;
      state_r.forward    <= 1'b1;
      state_r.mode_128   <= MODE128_RST;
      state_r.overridden <= 1'b0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/dcl_pkt_enc.sv
// Speed/direction packet encoder: address bytes plus 28- or 128-step byte(s).
// Depends on dcl_pkg; purely combinational.
module dcl_pkt_enc import dcl_pkg::*; (
  input  logic [ADDR_W-1:0] loco_address,
  input  loco_state_t       state,
  output pkt_t              pkt
);

  logic                 addr_ok;
  logic                 addr_long;
  logic [S28_NUM_W-1:0] s28_num;
  logic [2*S28_NUM_W-1:0] s28_prod;
  logic [4:0]           s28;
  logic [4:0]           v28;
  logic [6:0]           v128;
  logic [7:0]           spd_b0;
  logic [7:0]           spd_b1;
  logic                 spd_two;
  logic [7:0]           hi_byte;
  logic [7:0]           lo_byte;

  assign addr_ok   = (loco_address != '0) && (loco_address <= LOCO_ADDR_MAX);
  assign addr_long = (loco_address > SHORT_ADDR_MAX);
  assign hi_byte   = {LONG_ADDR_TAG, loco_address[ADDR_W-1:8]};
  assign lo_byte   = loco_address[7:0];

  // floor(num / 46) as (num * recip) >> shift, exact for num below 4681
  assign s28_num  = S28_NUM_W'(state.speed) * S28_NUM_W'(S28_MUL) + S28_NUM_W'(S28_ADD);
  assign s28_prod = (2*S28_NUM_W)'(s28_num) * (2*S28_NUM_W)'(S28_RECIP);
  assign s28      = 5'(s28_prod >> S28_SHIFT);
  assign v28      = (s28 == '0) ? 5'd0 : 5'(s28 + 5'(S28_OFS));

  always_comb begin
    if (state.estop) begin
      v128 = 7'd1;
    end else if (state.speed == '0) begin
      v128 = 7'd0;
    end else begin
      v128 = 7'(state.speed + 7'd1);
    end
  end

  always_comb begin
    spd_b1 = '0;
    if (state.mode_128) begin
      spd_two = 1'b1;
      spd_b0  = SPEED128_MARK;
      spd_b1  = {state.forward, v128};
    end else if (state.estop) begin
      spd_two = 1'b0;
      spd_b0  = ESTOP28_BYTE | (state.forward ? FWD28_BIT : 8'h00);
    end else begin
      spd_two = 1'b0;
      // 01DCSSSS: low speed bit moves up to C
      spd_b0  = SPEED28_BASE | {3'b000, v28[0], v28[4:1]} |
                (state.forward ? FWD28_BIT : 8'h00);
    end
  end

  always_comb begin
    pkt = '0;
    if (addr_ok) begin
      pkt.repeat_count = REPEAT_VALID;
      if (addr_long) begin
        pkt.byte0         = hi_byte;
        pkt.byte1         = lo_byte;
        pkt.byte2         = spd_b0;
        pkt.byte3         = spd_b1;
        pkt.packet_length = spd_two ? 3'd4 : 3'd3;
      end else begin
        pkt.byte0         = lo_byte;
        pkt.byte1         = spd_b0;
        pkt.byte2         = spd_b1;
        pkt.packet_length = spd_two ? 3'd3 : 3'd2;
      end
    end
  end

endmodule

FILE: rtl/core/dcc_loco_throttle_packet_builder_top.sv
// DCC loco throttle packet builder, one request in and one result beat out per
// request. A beat is registered on entry, then state update and packet encode
// run combinationally into the result register, which raises out_tvalid; with
// out_tready high one request is taken every clock. While a result waits, the
// input register can still take one more request.
// The packet reflects the state after the request is applied. Writing
// register 1 (initial step mode) has no effect on the live mode; reset loads
// 128-step mode. Depends on dcl_pkg, dcl_state, dcl_pkt_enc.
module dcc_loco_throttle_packet_builder_top import dcl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: dir_forward[0], speed_value[7:1], estop_request[8],
  //           steps_value[16:9], zero fill
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [REQ_W-1:0]       in_tuser,
  // out_tdata: changed[0], packet_length[3:1], packet_byte0[11:4],
  //            packet_byte1[19:12], packet_byte2[27:20], packet_byte3[35:28],
  //            repeat_count[37:36], zero fill
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic                   cfg_idx,
  input  logic [ADDR_W-1:0]      cfg_wdata
);

  item_t                  in_r;
  logic                   in_valid_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic [ADDR_W-1:0]      addr_r;
  logic                   advance;
  logic                   changed;
  loco_state_t            state_nxt;
  pkt_t                   pkt;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LOCO_ADDRESS:     addr_r <= cfg_wdata;
        CFG_INITIAL_MODE_128: ; // ignored; reset always loads MODE128_RST
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r.req_type      <= in_tuser;
      in_r.dir_forward   <= in_tdata[0];
      in_r.speed_value   <= in_tdata[7:1];
      in_r.estop_request <= in_tdata[8];
      in_r.steps_value   <= in_tdata[16:9];
    end
  end

  dcl_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (in_r),
    .changed   (changed),
    .state_nxt (state_nxt)
  );

  dcl_pkt_enc u_enc (
    .loco_address (addr_r),
    .state        (state_nxt),
    .pkt          (pkt)
  );

  assign out_data_nxt = {2'b00, pkt.repeat_count, pkt.byte3, pkt.byte2, pkt.byte1,
                         pkt.byte0, pkt.packet_length, changed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/dcl_chk.sv
// Port-level checker for the DCC loco throttle packet builder, bound to the top.
// Depends on dcl_pkg and the assertion macro header.
`include "dcc_loco_throttle_packet_builder_top_assert.svh"

module dcl_chk import dcl_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [REQ_W-1:0]       in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_we,
  input logic                   cfg_idx,
  input logic [ADDR_W-1:0]      cfg_wdata
);

  `DCL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `DCL_ASSERT_IMP(a_no_pkt_zero, out_tvalid && (out_tdata[3:1] == 3'd0), (out_tdata[37:36] == 2'd0) && (out_tdata[35:4] == 32'd0), "empty packet carries bytes or repeats")
  `DCL_ASSERT_IMP(a_pkt_shape, out_tvalid && (out_tdata[3:1] != 3'd0), (out_tdata[37:36] == REPEAT_VALID) && (out_tdata[3:1] >= 3'd2) && (out_tdata[3:1] <= 3'd4), "packet length or repeat count out of shape")
  `DCL_ASSERT_ANY(a_rst_idle, !rst_n, !out_tvalid && in_tready, "block not idle after reset")

endmodule

bind dcc_loco_throttle_packet_builder_top dcl_chk u_chk (.*);
